### rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and character codes for the C lexical context tracker.
// ----------------------------------------------------------------------------
package clt_pkg;

    // character codes the scanner reacts to
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_SLASH     = 8'h2F;

    // lexical context carried from byte to byte
    typedef struct packed {
        logic in_block_comment;
        logic in_string_lit;
        logic in_char_lit;
        logic backslash_continue;
        logic pending_slash;
        logic pending_star;
        logic skip_next_byte;
        logic rest_of_line_ignored;
    } clt_state_t;

    localparam clt_state_t CLT_STATE_RESET = '0;

    // one input item as held in the input register
    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_end;
        logic       line_empty;
    } clt_item_t;

endpackage

### rtl/clt_if.sv
// ----------------------------------------------------------------------------
// clt_in_if / clt_out_if
// Valid/ready channels for text items and context results.
// ----------------------------------------------------------------------------
interface clt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       line_end;
    logic       line_empty;

    modport source (output valid, output text_byte, output line_end, output line_empty,
                    input ready);
    modport sink   (input valid, input text_byte, input line_end, input line_empty,
                    output ready);
endinterface

interface clt_out_if;
    logic valid;
    logic ready;
    logic comment_open;
    logic string_open;
    logic char_open;
    logic continued_line;
    logic any_open;
    logic line_done;

    modport source (output valid, output comment_open, output string_open,
                    output char_open, output continued_line, output any_open,
                    output line_done, input ready);
    modport sink   (input valid, input comment_open, input string_open,
                    input char_open, input continued_line, input any_open,
                    input line_done, output ready);
endinterface

### rtl/clt_step.sv
// ----------------------------------------------------------------------------
// clt_step
// Next lexical context for one item: byte scan plus end-of-line handling.
// ----------------------------------------------------------------------------
module clt_step
(
    input  clt_pkg::clt_state_t cur,
    input  clt_pkg::clt_item_t  item,
    output clt_pkg::clt_state_t nxt
);

    // byte with no pending two-byte token
    function automatic clt_pkg::clt_state_t plain_byte(clt_pkg::clt_state_t s,
                                                      logic [7:0] b);
        clt_pkg::clt_state_t r;
        r = s;
        if (s.in_string_lit)
        begin
            if (b == clt_pkg::CH_BACKSLASH)
                r.skip_next_byte = 1'b1;
            else if (b == clt_pkg::CH_DQUOTE)
                r.in_string_lit = 1'b0;
        end
        else if (s.in_char_lit)
        begin
            if (b == clt_pkg::CH_BACKSLASH)
                r.skip_next_byte = 1'b1;
            else if (b == clt_pkg::CH_SQUOTE)
                r.in_char_lit = 1'b0;
        end
        else if (s.in_block_comment)
        begin
            if (b == clt_pkg::CH_STAR)
                r.pending_star = 1'b1;
        end
        else
        begin
            if (b == clt_pkg::CH_SLASH)
                r.pending_slash = 1'b1;
            else if (b == clt_pkg::CH_DQUOTE)
                r.in_string_lit = 1'b1;
            else if (b == clt_pkg::CH_SQUOTE)
                r.in_char_lit = 1'b1;
        end
        return r;
    endfunction

    // byte scan with skip, ignore and two-byte tokens
    function automatic clt_pkg::clt_state_t scan_byte(clt_pkg::clt_state_t s,
                                                     logic [7:0] b);
        clt_pkg::clt_state_t r;
        r = s;
        priority if (s.skip_next_byte)
        begin
            r.skip_next_byte = 1'b0;
        end
        else if (s.rest_of_line_ignored)
        begin
            r = s;
        end
        else if (s.pending_slash)
        begin
            r.pending_slash = 1'b0;
            if (b == clt_pkg::CH_STAR)
                r.in_block_comment = 1'b1;
            else if (b == clt_pkg::CH_SLASH)
                r.rest_of_line_ignored = 1'b1;
            else
                r = plain_byte(r, b);
        end
        else if (s.pending_star)
        begin
            r.pending_star = 1'b0;
            if (b == clt_pkg::CH_SLASH)
                r.in_block_comment = 1'b0;
            else
                r = plain_byte(r, b);
        end
        else
        begin
            r = plain_byte(s, b);
        end
        return r;
    endfunction

    // end of line: clear per-line flags, keep literals only on continuation
    function automatic clt_pkg::clt_state_t close_line(clt_pkg::clt_state_t s,
                                                      logic cont);
        clt_pkg::clt_state_t r;
        r = s;
        r.pending_slash        = 1'b0;
        r.pending_star         = 1'b0;
        r.skip_next_byte       = 1'b0;
        r.rest_of_line_ignored = 1'b0;
        r.backslash_continue   = cont;
        if (!cont)
        begin
            r.in_string_lit = 1'b0;
            r.in_char_lit   = 1'b0;
        end
        return r;
    endfunction

    logic final_backslash;

    assign final_backslash = (item.text_byte == clt_pkg::CH_BACKSLASH);

    // item kinds: empty line, last byte, byte within a line
    always_comb
    begin
        priority if (item.line_empty)
        begin
            nxt = close_line(cur, 1'b0);
        end
        else if (item.line_end)
        begin
            if (final_backslash)
                nxt = close_line(cur, 1'b1);
            else
                nxt = close_line(scan_byte(cur, item.text_byte), 1'b0);
        end
        else
        begin
            nxt = scan_byte(cur, item.text_byte);
            nxt.backslash_continue = 1'b0;
        end
    end

endmodule

### rtl/c_lexical_context_tracker.sv
// ----------------------------------------------------------------------------
// c_lexical_context_tracker
// Tracks block comment, string and character literal context in C text.
// ----------------------------------------------------------------------------
// Takes one text item per clock unless the result side stalls and returns
// one result per item, in order. An item is captured in the input register,
// the context update is combinational between that register and the result
// register, so the result turns valid when the item advances into the result
// register, which back-pressure can delay; throughput is one item per cycle
// while not stalled, and the only loop is the context register feedback.
// Back-pressure on the result side stalls the input register, and the input
// side stays ready while a held result leaves in the same cycle.
module c_lexical_context_tracker
(
    input  logic            clk,
    input  logic            rst_n,
    clt_in_if.sink          in_ch,
    clt_out_if.source       out_ch
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    clt_pkg::clt_item_t  s1_item_reg;
    clt_pkg::clt_state_t ctx_reg;
    clt_pkg::clt_state_t ctx_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                line_done_reg;
    logic                in_xfer;
    logic                out_adv;
    logic                s1_adv;

    // pipeline handshake
    assign out_adv     = !out_valid_reg || out_ch.ready;
    assign s1_adv      = s1_valid_reg && out_adv;
    assign in_ch.ready = !s1_valid_reg || out_adv;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ch.ready)
            s1_valid_next = in_ch.valid;
        out_valid_next = out_valid_reg;
        if (out_adv)
            out_valid_next = s1_valid_reg;
    end

    // context update for the item in the input register
    clt_step u_step
    (
        .cur  (ctx_reg),
        .item (s1_item_reg),
        .nxt  (ctx_next)
    );

    // control and context registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctx_reg       <= clt_pkg::CLT_STATE_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
                ctx_reg <= ctx_next;
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg.text_byte  <= in_ch.text_byte;
            s1_item_reg.line_end   <= in_ch.line_end;
            s1_item_reg.line_empty <= in_ch.line_empty;
        end
    end

    // result payload: line closure flag; context flags come from ctx_reg
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            line_done_reg <= s1_item_reg.line_end || s1_item_reg.line_empty;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.comment_open   = ctx_reg.in_block_comment;
    assign out_ch.string_open    = ctx_reg.in_string_lit;
    assign out_ch.char_open      = ctx_reg.in_char_lit;
    assign out_ch.continued_line = ctx_reg.backslash_continue;
    assign out_ch.any_open       = ctx_reg.in_block_comment || ctx_reg.in_string_lit ||
                                   ctx_reg.in_char_lit || ctx_reg.backslash_continue;
    assign out_ch.line_done      = line_done_reg;

endmodule

### rtl/clt_checker.sv
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks on the result channel of the context tracker.
// ----------------------------------------------------------------------------
module clt_checker
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic comment_open,
    input logic string_open,
    input logic char_open,
    input logic continued_line,
    input logic any_open,
    input logic line_done
);

    // continuation is only reported on a line-closing result
    a_cont_only_at_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_done |-> !continued_line)
        else $error("continued_line set on a result that does not close a line");

    // summary flag matches the individual flags
    a_any_open_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (any_open == (comment_open || string_open || char_open ||
                                    continued_line)))
        else $error("any_open disagrees with the individual flags");

    // a line closed without continuation leaves no literal open
    a_literals_close: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done && !continued_line |-> !string_open && !char_open)
        else $error("literal still open after an uncontinued line end");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind c_lexical_context_tracker clt_checker u_clt_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .comment_open   (out_ch.comment_open),
    .string_open    (out_ch.string_open),
    .char_open      (out_ch.char_open),
    .continued_line (out_ch.continued_line),
    .any_open       (out_ch.any_open),
    .line_done      (out_ch.line_done)
);
